### src/fcip_pkg.sv
package fcip_pkg;

  // Field and datapath widths
  localparam int unsigned FricW    = 21;  // friction coefficient, unsigned Q5.16
  localparam int unsigned ValW     = 32;  // impulse / cohesion, signed Q16.16
  localparam int unsigned CohW     = 31;  // effective cohesion, never negative
  localparam int unsigned GW       = 33;  // shifted normal, signed
  localparam int unsigned MuGW     = 55;  // mu * g, signed
  localparam int unsigned TmuW     = 53;  // t * mu
  localparam int unsigned RootW    = 32;  // tangent magnitude
  localparam int unsigned NumW     = 54;  // projected-normal dividend
  localparam int unsigned DenW     = 27;  // 1 + mu^2 divisor
  localparam int unsigned GpW      = 38;  // projected normal
  localparam int unsigned ProdW    = 59;  // g' * mu
  localparam int unsigned RatioQW  = 16;  // ratio quotient below 1.0
  localparam int unsigned RatioW   = 17;  // ratio incl. 1.0
  localparam int unsigned SatInW   = 40;  // saturator input
  localparam int unsigned CmpW     = 56;  // cone compare width
  localparam int unsigned FracBits = 16;
  localparam int unsigned OneQ     = 65536;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned QueueDepthDef = 4;

  typedef enum logic [1:0] {
    OUT_INSIDE       = 2'd0,
    OUT_ZEROED       = 2'd1,
    OUT_PROJECTED    = 2'd2,
    OUT_FRICTIONLESS = 2'd3
  } outcome_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CONT_FRICTION = 1'b0,
    REG_CONT_COHESION = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [FricW-1:0]       body_friction;
    logic signed [ValW-1:0] body_cohesion;
    logic signed [ValW-1:0] impulse_normal_in;
    logic signed [ValW-1:0] impulse_u_in;
    logic signed [ValW-1:0] impulse_v_in;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] impulse_normal_out;
    logic signed [ValW-1:0] impulse_u_out;
    logic signed [ValW-1:0] impulse_v_out;
    logic [1:0]             outcome;
  } out_item_t;

  // Contact record carried through the front end
  typedef struct packed {
    logic [FricW-1:0]       mu;
    logic                   mu_zero;
    logic [CohW-1:0]        coh;
    logic signed [GW-1:0]   g;
    logic signed [ValW-1:0] n;
    logic signed [ValW-1:0] u;
    logic signed [ValW-1:0] v;
    logic signed [MuGW-1:0] mug;
  } front_side_t;

  // Classified contact, as queued between front and back end
  typedef struct packed {
    outcome_e               outcome;
    logic [FricW-1:0]       mu;
    logic [CohW-1:0]        coh;
    logic signed [GW-1:0]   g;
    logic signed [ValW-1:0] n;
    logic signed [ValW-1:0] u;
    logic signed [ValW-1:0] v;
    logic [RootW-1:0]       t;
    logic [TmuW-1:0]        tmu;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [ValW-1:0] abs_val(input logic signed [ValW-1:0] x);
    abs_val = x[ValW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [ValW-1:0] sat_val(input logic signed [SatInW-1:0] x);
    if (!x[SatInW-1] && (|x[SatInW-2:ValW-1])) begin
      sat_val = {1'b0, {(ValW-1){1'b1}}};
    end else if (x[SatInW-1] && !(&x[SatInW-2:ValW-1])) begin
      sat_val = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      sat_val = x[ValW-1:0];
    end
  endfunction

endpackage

### src/fcip_chan_if.sv
interface fcip_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/fcip_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module fcip_isqrt #(
  parameter int unsigned RootW = 32,
  parameter type side_t = logic
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  side_t              side_i,
  input  logic [2*RootW-1:0] rad_i,
  output logic               vld_o,
  output side_t              side_o,
  output logic [RootW-1:0]   root_o
);
  localparam int unsigned RemW = RootW + 2;

  logic [RemW-1:0]    rem_q  [RootW];
  logic [RemW-1:0]    rem_d  [RootW];
  logic [RootW-1:0]   root_q [RootW];
  logic [RootW-1:0]   root_d [RootW];
  logic [2*RootW-1:0] xs_q   [RootW];
  logic [2*RootW-1:0] xs_d   [RootW];
  side_t              side_q [RootW];
  side_t              side_d [RootW];
  logic [RootW-1:0]   vld_q, vld_d;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW-1:0]    rem_a;
    logic [RootW-1:0]   root_a;
    logic [2*RootW-1:0] xs_a;
    logic [RemW+1:0]    x2;
    logic [RemW+2:0]    diff;
    if (k == 0) begin : g_first
      assign rem_a      = '0;
      assign root_a     = '0;
      assign xs_a       = rad_i;
      assign side_d[k]  = side_i;
      assign vld_d[k]   = vld_i;
    end else begin : g_next
      assign rem_a      = rem_q[k-1];
      assign root_a     = root_q[k-1];
      assign xs_a       = xs_q[k-1];
      assign side_d[k]  = side_q[k-1];
      assign vld_d[k]   = vld_q[k-1];
    end
    assign x2   = {rem_a, xs_a[2*RootW-1 -: 2]};
    assign diff = {1'b0, x2} - {3'b000, root_a, 2'b01};
    assign rem_d[k]  = diff[RemW+2] ? x2[RemW-1:0] : diff[RemW-1:0];
    assign root_d[k] = {root_a[RootW-2:0], ~diff[RemW+2]};
    assign xs_d[k]   = {xs_a[2*RootW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      xs_q   <= xs_d;
      side_q <= side_d;
    end
  end

  assign vld_o  = vld_q[RootW-1];
  assign side_o = side_q[RootW-1];
  assign root_o = root_q[RootW-1];
endmodule

### src/fcip_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit in QuoW bits (num < den << QuoW).
module fcip_div #(
  parameter int unsigned NumW = 8,
  parameter int unsigned DivW = 8,
  parameter int unsigned QuoW = 8,
  parameter type side_t = logic
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  side_t           side_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  output logic            vld_o,
  output side_t           side_o,
  output logic [QuoW-1:0] quo_o
);
  logic [DivW-1:0] rem_q  [QuoW];
  logic [DivW-1:0] rem_d  [QuoW];
  logic [QuoW-1:0] lq_q   [QuoW];
  logic [QuoW-1:0] lq_d   [QuoW];
  logic [DivW-1:0] den_q  [QuoW];
  logic [DivW-1:0] den_d  [QuoW];
  side_t           side_q [QuoW];
  side_t           side_d [QuoW];
  logic [QuoW-1:0] vld_q, vld_d;

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic [DivW-1:0] rem_a;
    logic [QuoW-1:0] lq_a;
    logic [DivW:0]   trial;
    logic [DivW:0]   diff;
    if (k == 0) begin : g_first
      assign rem_a     = DivW'(num_i >> QuoW);
      assign lq_a      = num_i[QuoW-1:0];
      assign den_d[k]  = den_i;
      assign side_d[k] = side_i;
      assign vld_d[k]  = vld_i;
    end else begin : g_next
      assign rem_a     = rem_q[k-1];
      assign lq_a      = lq_q[k-1];
      assign den_d[k]  = den_q[k-1];
      assign side_d[k] = side_q[k-1];
      assign vld_d[k]  = vld_q[k-1];
    end
    assign trial    = {rem_a, lq_a[QuoW-1]};
    assign diff     = trial - {1'b0, den_d[k]};
    assign rem_d[k] = diff[DivW] ? trial[DivW-1:0] : diff[DivW-1:0];
    assign lq_d[k]  = {lq_a[QuoW-2:0], ~diff[DivW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      lq_q   <= lq_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign vld_o  = vld_q[QuoW-1];
  assign side_o = side_q[QuoW-1];
  assign quo_o  = lq_q[QuoW-1];
endmodule

### src/fcip_front.sv
// Front end: effective friction/cohesion, tangent magnitude, cone classification.
module fcip_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             vld_i,
  input  fcip_pkg::in_item_t               item_i,
  output logic                             rdy_o,
  input  logic [fcip_pkg::FricW-1:0]       cont_fric_i,
  input  logic signed [fcip_pkg::ValW-1:0] cont_coh_i,
  input  fcip_pkg::q_stat_t                q_stat_i,
  output logic                             push_o,
  output fcip_pkg::q_item_t                item_o
);
  import fcip_pkg::*;

  logic en;

  // F0: effective coefficients
  logic [FricW:0]         fsum;
  logic signed [ValW:0]   csum;
  front_side_t            f0_d, f0_q;
  logic [ValW-1:0]        f0_au_q, f0_av_q;
  logic                   f0_vld_q;

  // F1: squares and mu*g
  front_side_t            f1_d, f1_q;
  logic [2*ValW-1:0]      f1_squ_q, f1_sqv_q;
  logic                   f1_vld_q;

  // F2: sum of squares
  front_side_t            f2_q;
  logic [2*RootW-1:0]     f2_rad_q;
  logic                   f2_vld_q;

  // root pipeline
  front_side_t            sq_side;
  logic [RootW-1:0]       sq_root;
  logic                   sq_vld;

  // F3: t*mu and inside test
  front_side_t            f3_q;
  logic [RootW-1:0]       f3_t_q;
  logic [TmuW-1:0]        f3_tmu_q;
  logic                   f3_inside_q;
  logic                   f3_vld_q;

  // F4: classified record
  logic signed [CmpW-1:0] gsh;
  logic                   dual;
  q_item_t                f4_d, f4_q;
  logic                   f4_vld_q;

  assign en     = !f4_vld_q || !q_stat_i.full;
  assign rdy_o  = en;
  assign push_o = f4_vld_q && !q_stat_i.full;
  assign item_o = f4_q;

  always_comb begin
    fsum = {1'b0, item_i.body_friction} + {1'b0, cont_fric_i};
    csum = {item_i.body_cohesion[ValW-1], item_i.body_cohesion}
         + {cont_coh_i[ValW-1], cont_coh_i};
    f0_d.mu_zero = (item_i.body_friction == '0) || (cont_fric_i == '0);
    f0_d.mu      = f0_d.mu_zero ? '0 : fsum[FricW:1];
    f0_d.coh     = (!csum[ValW] && (csum != '0)) ? csum[ValW-1:1] : '0;
    f0_d.g       = {item_i.impulse_normal_in[ValW-1], item_i.impulse_normal_in}
                 + $signed({2'b00, f0_d.coh});
    f0_d.n       = item_i.impulse_normal_in;
    f0_d.u       = item_i.impulse_u_in;
    f0_d.v       = item_i.impulse_v_in;
    f0_d.mug     = '0;
  end

  always_comb begin
    f1_d     = f0_q;
    f1_d.mug = $signed({1'b0, f0_q.mu}) * f0_q.g;
  end

  // shifted-normal term of the dual-cone test
  assign gsh  = $signed({{(CmpW-GW-FracBits){f3_q.g[GW-1]}}, f3_q.g, {FracBits{1'b0}}});
  assign dual = ($signed({{(CmpW-TmuW){1'b0}}, f3_tmu_q}) < -gsh) || (f3_q.g == '0);

  always_comb begin
    f4_d.mu  = f3_q.mu;
    f4_d.coh = f3_q.coh;
    f4_d.g   = f3_q.g;
    f4_d.n   = f3_q.n;
    f4_d.u   = f3_q.u;
    f4_d.v   = f3_q.v;
    f4_d.t   = f3_t_q;
    f4_d.tmu = f3_tmu_q;
    priority if (f3_q.mu_zero) begin
      f4_d.outcome = OUT_FRICTIONLESS;
    end else if (f3_inside_q) begin
      f4_d.outcome = OUT_INSIDE;
    end else if (dual) begin
      f4_d.outcome = OUT_ZEROED;
    end else begin
      f4_d.outcome = OUT_PROJECTED;
    end
  end

  fcip_isqrt #(
    .RootW (RootW),
    .side_t(front_side_t)
  ) u_isqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (f2_vld_q),
    .side_i(f2_q),
    .rad_i (f2_rad_q),
    .vld_o (sq_vld),
    .side_o(sq_side),
    .root_o(sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_vld_q <= 1'b0;
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
      f4_vld_q <= 1'b0;
    end else if (en) begin
      f0_vld_q <= vld_i;
      f1_vld_q <= f0_vld_q;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= sq_vld;
      f4_vld_q <= f3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_q     <= f0_d;
      f0_au_q  <= abs_val(item_i.impulse_u_in);
      f0_av_q  <= abs_val(item_i.impulse_v_in);

      f1_q     <= f1_d;
      f1_squ_q <= f0_au_q * f0_au_q;
      f1_sqv_q <= f0_av_q * f0_av_q;

      f2_q     <= f1_q;
      f2_rad_q <= f1_squ_q + f1_sqv_q;

      f3_q        <= sq_side;
      f3_t_q      <= sq_root;
      f3_tmu_q    <= sq_root * sq_side.mu;
      f3_inside_q <= $signed({{(CmpW-RootW-FracBits){1'b0}}, sq_root, {FracBits{1'b0}}})
                   < $signed({{(CmpW-MuGW){sq_side.mug[MuGW-1]}}, sq_side.mug});

      f4_q <= f4_d;
    end
  end
endmodule

### src/fcip_queue.sv
// Small register queue between front and back end.
module fcip_queue #(
  parameter int unsigned Depth = 4,
  parameter type item_t = logic
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  item_t             item_i,
  input  logic              pop_i,
  output item_t             item_o,
  output fcip_pkg::q_stat_t stat_o
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end
endmodule

### src/fcip_back.sv
// Back end: orthogonal projection, tangent scaling, result select and saturation.
module fcip_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fcip_pkg::q_stat_t   q_stat_i,
  input  fcip_pkg::q_item_t   item_i,
  output logic                pop_o,
  input  logic                out_rdy_i,
  output logic                out_vld_o,
  output fcip_pkg::out_item_t out_item_o
);
  import fcip_pkg::*;

  typedef struct packed {
    q_item_t                  it;
    logic signed [SatInW-1:0] onp;
    logic                     sat;
  } b_side_t;

  logic en;

  // B0: dividend and divisor of the projected normal
  logic signed [CmpW-1:0]  gsh;
  logic signed [CmpW-1:0]  num_w;
  logic [2*FricW-1:0]      mm;
  q_item_t                 b0_q;
  logic [NumW-1:0]         b0_num_q;
  logic [DenW-1:0]         b0_den_q;
  logic                    b0_vld_q;

  q_item_t                 d1_side;
  logic [GpW-1:0]          d1_gp;
  logic                    d1_vld;

  // B1: g'*mu, normal result
  b_side_t                 b1_d, b1_q;
  logic [ProdW-1:0]        b1_prod_q;
  logic                    b1_vld_q;

  // B2: ratio clamp test
  b_side_t                 b2_d, b2_q;
  logic [ProdW-1:0]        b2_prod_q;
  logic                    b2_vld_q;

  b_side_t                 d2_side;
  logic [RatioQW-1:0]      d2_quo;
  logic                    d2_vld;

  // B3: tangent scaling
  logic [RatioW-1:0]       ratio;
  b_side_t                 b3_q;
  logic [ValW+RatioW-1:0]  b3_mu_q, b3_mv_q;
  logic                    b3_vld_q;

  // output register
  logic [ValW+1:0]         tu, tv;
  logic signed [ValW+1:0]  su, sv;
  out_item_t               out_d, out_q;
  logic                    out_vld_q;

  assign en         = !out_vld_q || out_rdy_i;
  assign pop_o      = en && !q_stat_i.empty;
  assign out_vld_o  = out_vld_q;
  assign out_item_o = out_q;

  assign gsh   = $signed({{(CmpW-GW-FracBits){item_i.g[GW-1]}}, item_i.g, {FracBits{1'b0}}});
  assign num_w = $signed({{(CmpW-TmuW){1'b0}}, item_i.tmu}) + gsh;
  assign mm    = item_i.mu * item_i.mu;

  fcip_div #(
    .NumW  (NumW),
    .DivW  (DenW),
    .QuoW  (GpW),
    .side_t(q_item_t)
  ) u_div_gp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (b0_vld_q),
    .side_i(b0_q),
    .num_i (b0_num_q),
    .den_i (b0_den_q),
    .vld_o (d1_vld),
    .side_o(d1_side),
    .quo_o (d1_gp)
  );

  always_comb begin
    b1_d.it  = d1_side;
    b1_d.onp = $signed({2'b00, d1_gp}) - $signed({{(SatInW-CohW){1'b0}}, d1_side.coh});
    b1_d.sat = 1'b0;
  end

  // ratio saturates once g'*mu reaches t
  always_comb begin
    b2_d     = b1_q;
    b2_d.sat = b1_prod_q >= ProdW'({b1_q.it.t, {FracBits{1'b0}}});
  end

  fcip_div #(
    .NumW  (ProdW),
    .DivW  (RootW),
    .QuoW  (RatioQW),
    .side_t(b_side_t)
  ) u_div_ratio (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (b2_vld_q),
    .side_i(b2_q),
    .num_i (b2_prod_q),
    .den_i (b2_q.it.t),
    .vld_o (d2_vld),
    .side_o(d2_side),
    .quo_o (d2_quo)
  );

  // ratio is clamped at 1.0
  assign ratio = d2_side.sat ? RatioW'(OneQ) : {1'b0, d2_quo};

  always_comb begin
    tu = {1'b0, b3_mu_q[ValW+RatioW-1:FracBits]};
    tv = {1'b0, b3_mv_q[ValW+RatioW-1:FracBits]};
    su = b3_q.it.u[ValW-1] ? -$signed(tu) : $signed(tu);
    sv = b3_q.it.v[ValW-1] ? -$signed(tv) : $signed(tv);
    out_d.outcome = b3_q.it.outcome;
    unique case (b3_q.it.outcome)
      OUT_INSIDE: begin
        out_d.impulse_normal_out = b3_q.it.n;
        out_d.impulse_u_out      = b3_q.it.u;
        out_d.impulse_v_out      = b3_q.it.v;
      end
      OUT_ZEROED: begin
        out_d.impulse_normal_out = -$signed({1'b0, b3_q.it.coh});
        out_d.impulse_u_out      = '0;
        out_d.impulse_v_out      = '0;
      end
      OUT_PROJECTED: begin
        out_d.impulse_normal_out = sat_val(b3_q.onp);
        out_d.impulse_u_out      = sat_val(SatInW'(su));
        out_d.impulse_v_out      = sat_val(SatInW'(sv));
      end
      OUT_FRICTIONLESS: begin
        out_d.impulse_normal_out = b3_q.it.g[GW-1] ? '0 : b3_q.it.n;
        out_d.impulse_u_out      = '0;
        out_d.impulse_v_out      = '0;
      end
      default: begin
        out_d.impulse_normal_out = '0;
        out_d.impulse_u_out      = '0;
        out_d.impulse_v_out      = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_vld_q  <= 1'b0;
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      b3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      b0_vld_q  <= !q_stat_i.empty;
      b1_vld_q  <= d1_vld;
      b2_vld_q  <= b1_vld_q;
      b3_vld_q  <= d2_vld;
      out_vld_q <= b3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q     <= item_i;
      b0_num_q <= num_w[NumW-1:0];
      b0_den_q <= DenW'(mm[2*FricW-1:FracBits]) + DenW'(OneQ);

      b1_q      <= b1_d;
      b1_prod_q <= d1_gp * d1_side.mu;

      b2_q      <= b2_d;
      b2_prod_q <= b1_prod_q;

      b3_q    <= d2_side;
      b3_mu_q <= abs_val(d2_side.it.u) * ratio;
      b3_mv_q <= abs_val(d2_side.it.v) * ratio;

      out_q <= out_d;
    end
  end
endmodule

### src/friction_cone_impulse_projector_top.sv
// Coulomb friction cone projector, one contact per item. Each item carries a
// body's friction and cohesion and the contact's normal and two tangent
// impulses (signed Q16.16); the result is the projected impulse, cohesion
// removed again, saturated to 32 bits, plus an outcome code (inside cone,
// zeroed, projected, frictionless). Container friction and cohesion are
// written through the config port (index 0 friction, index 1 cohesion);
// the user must write them only while the block is idle; the block does
// not enforce this. Throughput is one item per clock, sustained, as long as
// the output is taken. The front-end delay is set by the 32-stage square
// root of the tangent magnitude, the back-end delay by the 38-stage divider
// for the projected normal and the 16-stage divider for the tangent ratio,
// with the queue between them. A stall at the output first fills the queue
// (QueueDepth items) before the input stops taking items.
module friction_cone_impulse_projector_top #(
  parameter int unsigned QueueDepth = fcip_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fcip_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fcip_pkg::ValW-1:0]    cfg_data_i,
  fcip_chan_if.sink                    in_ch_i,
  fcip_chan_if.source                  out_ch_o
);
  import fcip_pkg::*;

  // container coefficients
  logic [FricW-1:0]       cont_fric_q;
  logic signed [ValW-1:0] cont_coh_q;

  // front -> queue -> back
  logic    push;
  logic    pop;
  q_item_t push_item;
  q_item_t head_item;
  q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_fric_q <= '0;
      cont_coh_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CONT_FRICTION: cont_fric_q <= cfg_data_i[FricW-1:0];
        REG_CONT_COHESION: cont_coh_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end: mu, cohesion, |tangent| and cone classification
  fcip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (in_ch_i.valid),
    .item_i     (in_ch_i.payload),
    .rdy_o      (in_ch_i.ready),
    .cont_fric_i(cont_fric_q),
    .cont_coh_i (cont_coh_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .item_o     (push_item)
  );

  // decouples the two pipelines so each stalls on its own
  fcip_queue #(
    .Depth (QueueDepth),
    .item_t(q_item_t)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .item_i(push_item),
    .pop_i (pop),
    .item_o(head_item),
    .stat_o(q_stat)
  );

  // back end: projection arithmetic and result register
  fcip_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .item_i    (head_item),
    .pop_o     (pop),
    .out_rdy_i (out_ch_o.ready),
    .out_vld_o (out_ch_o.valid),
    .out_item_o(out_ch_o.payload)
  );

  a_queue_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("item pushed into full queue");

  a_queue_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("item popped from empty queue");

  a_zero_tangents : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && (out_ch_o.payload.outcome == OUT_ZEROED ||
                        out_ch_o.payload.outcome == OUT_FRICTIONLESS))
    |-> (out_ch_o.payload.impulse_u_out == '0 && out_ch_o.payload.impulse_v_out == '0))
    else $error("non-zero tangent on zeroed or frictionless contact");
endmodule

### tb/sv/fcip_cone_checker.sv
`default_nettype none

module fcip_cone_checker
  import fcip_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ValW-1:0]     cfg_data_i,
  fcip_chan_if                in_mon,
  fcip_chan_if                out_mon,
  output int                  fail_cnt_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [FricW-1:0] cont_fric_q;
  logic [ValW-1:0]  cont_coh_q;
  out_item_t        impulse_q[$];

  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [ValW-1:0] clip32(input longint x);
    if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'h8000_0000;
    return x[ValW-1:0];
  endfunction

  function automatic longint scale_tangent(input longint x, input longint ratio);
    longint unsigned ax, m;
    ax = (x < 0) ? longint'(-x) : x;
    m  = (ax * longint'(ratio)) >> FracBits;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic out_item_t project(input in_item_t it, input logic [FricW-1:0] cf,
                                        input logic [ValW-1:0] cc);
    longint bf, mu, csum, coh, g, n, u, v, t, den, gp, ratio, on, ou, ov, q1;
    longint unsigned au, av;
    out_item_t r;
    q1   = OneQ;  // signed 1.0 keeps the cone compares signed
    bf   = it.body_friction;
    csum = longint'($signed(it.body_cohesion)) + longint'($signed(cc));
    n    = $signed(it.impulse_normal_in);
    u    = $signed(it.impulse_u_in);
    v    = $signed(it.impulse_v_in);
    mu   = (bf == 0 || cf == 0) ? 0 : (bf + longint'(cf)) / 2;
    coh  = (csum > 0) ? csum / 2 : 0;
    g    = n + coh;
    if (mu == 0) begin
      on = (g < 0) ? 0 : n;
      ou = 0;
      ov = 0;
      r.outcome = OUT_FRICTIONLESS;
    end else begin
      au = (u < 0) ? longint'(-u) : u;
      av = (v < 0) ? longint'(-v) : v;
      t  = root64(au * au + av * av);
      if (t * q1 < mu * g) begin
        on = n;
        ou = u;
        ov = v;
        r.outcome = OUT_INSIDE;
      end else if (t * mu < -g * q1 || g == 0) begin
        on = -coh;
        ou = 0;
        ov = 0;
        r.outcome = OUT_ZEROED;
      end else begin
        den   = ((mu * mu) / q1) + q1;
        gp    = (t * mu + g * q1) / den;
        ratio = (gp * mu) / t;
        if (ratio > q1) ratio = q1;
        on = gp - coh;
        ou = scale_tangent(u, ratio);
        ov = scale_tangent(v, ratio);
        r.outcome = OUT_PROJECTED;
      end
    end
    r.impulse_normal_out = clip32(on);
    r.impulse_u_out      = clip32(ou);
    r.impulse_v_out      = clip32(ov);
    return r;
  endfunction

  assign pending_o = impulse_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_fric_q <= '0;
      cont_coh_q  <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CONT_FRICTION: cont_fric_q <= cfg_data_i[FricW-1:0];
        REG_CONT_COHESION: cont_coh_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_item_t got, want;
    if (!rst_ni) begin
      fail_cnt_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        impulse_q.push_back(project(in_item_t'(in_mon.payload), cont_fric_q, cont_coh_q));
      if (out_mon.valid && out_mon.ready) begin
        got = out_item_t'(out_mon.payload);
        if (impulse_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          fail_cnt_o++;
        end else begin
          want = impulse_q.pop_front();
          if (got.impulse_normal_out !== want.impulse_normal_out) begin
            $display("%0t: normal exp %h got %h", $realtime,
                     want.impulse_normal_out, got.impulse_normal_out);
            fail_cnt_o++;
          end
          if (got.impulse_u_out !== want.impulse_u_out) begin
            $display("%0t: tangent u exp %h got %h", $realtime,
                     want.impulse_u_out, got.impulse_u_out);
            fail_cnt_o++;
          end
          if (got.impulse_v_out !== want.impulse_v_out) begin
            $display("%0t: tangent v exp %h got %h", $realtime,
                     want.impulse_v_out, got.impulse_v_out);
            fail_cnt_o++;
          end
          if (got.outcome !== want.outcome) begin
            $display("%0t: outcome exp %0d got %0d", $realtime, want.outcome, got.outcome);
            fail_cnt_o++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### tb/sv/friction_cone_impulse_projector_top_tb.sv
`default_nettype none

module friction_cone_impulse_projector_top_tb;
  import fcip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ValW-1:0]    cfg_data_i;
  int                 fail_cnt;
  int                 pending;
  int                 hold_req_cnt;  // bumped by stimulus, one long hold-off each
  int                 hold_done_cnt;

  fcip_chan_if #(.payload_t(in_item_t))  in_ch ();
  fcip_chan_if #(.payload_t(out_item_t)) out_ch ();

  friction_cone_impulse_projector_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  fcip_cone_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard limit: far beyond the slowest legal run (~650 items, stalls, drains)
  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: the ready pattern periodically switches to a random mode; a
  // hold-off request drops ready so the queue fills and the input stalls.
  initial begin
    int mode, cyc, hold;
    out_ch.ready = 1'b0;
    mode = 0;
    cyc  = 0;
    hold = 0;
    hold_done_cnt = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold == 0 && hold_done_cnt != hold_req_cnt) begin
        hold = 400;
        hold_done_cnt++;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  int burst_left;

  // Offer one item; valid stays high into the next item of a burst
  task automatic push_contact(input in_item_t it);
    int gap;
    @(negedge clk_i);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [ValW-1:0] data);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Idle before a register write: all results in, then a latency's worth more
  task automatic drain_all();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Impulse of random magnitude so every outcome shows up
  function automatic logic [ValW-1:0] rand_impulse();
    logic [ValW-1:0] x;
    case ($urandom_range(0, 5))
      0: x = $urandom();
      1: x = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: x = $urandom_range(0, 2) - 1;
      default: begin
        x = $urandom() >> $urandom_range(4, 31);
        if ($urandom_range(0, 1)) x = -x;
      end
    endcase
    return x;
  endfunction

  function automatic in_item_t rand_contact();
    in_item_t it;
    case ($urandom_range(0, 7))
      0: it.body_friction = '0;
      1: it.body_friction = FricW'($urandom());
      2: it.body_friction = 21'h10_0000;
      default: it.body_friction = FricW'($urandom_range(1, 3 * OneQ));
    endcase
    it.body_cohesion     = ($urandom_range(0, 2) == 0) ? 32'h0 : rand_impulse();
    it.impulse_normal_in = rand_impulse();
    it.impulse_u_in      = rand_impulse();
    it.impulse_v_in      = rand_impulse();
    return it;
  endfunction

  function automatic in_item_t mk(input logic [FricW-1:0] f, input logic [ValW-1:0] c,
                                  input logic [ValW-1:0] n, input logic [ValW-1:0] u,
                                  input logic [ValW-1:0] v);
    in_item_t it;
    it.body_friction     = f;
    it.body_cohesion     = c;
    it.impulse_normal_in = n;
    it.impulse_u_in      = u;
    it.impulse_v_in      = v;
    return it;
  endfunction

  initial begin
    logic [FricW-1:0] fric_set [6];
    logic [ValW-1:0]  coh_set [6];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_CONT_FRICTION;
    cfg_data_i    = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    hold_req_cnt  = 0;
    burst_left    = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: mu = 1.0, no container cohesion
    write_reg(REG_CONT_FRICTION, OneQ);
    write_reg(REG_CONT_COHESION, 32'h0);
    push_contact(mk(FricW'(OneQ), 0, 32'h0002_0000, 32'h0000_8000, 32'h0000_8000)); // inside
    push_contact(mk(FricW'(OneQ), 0, 32'hFFFE_0000, 32'h0000_1000, 32'h0));     // dual cone
    push_contact(mk(FricW'(OneQ), 0, 32'h0, 32'h0001_0000, 32'h0));             // zero normal
    push_contact(mk(FricW'(OneQ), 0, 32'h0001_0000, 32'h0003_0000, 32'hFFFC_0000)); // proj
    push_contact(mk(0, 0, 32'hFFFF_0000, 32'h1234, 32'h5678));               // frictionless <0
    push_contact(mk(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));     // frictionless
    push_contact(mk(21'h1F_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    push_contact(mk(21'h1F_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0)); // inside
    push_contact(mk(21'h10_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000));
    push_contact(mk(1, 32'h0001_0000, 32'h0, 32'h0, 32'h0));                 // tiny body friction
    push_contact(mk(FricW'(OneQ), 32'h0004_0000, 32'hFFFF_0000, 32'h0, 32'h0)); // cohesion lifts
    push_contact(mk(FricW'(OneQ), 32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h0001_0000)); // edge
    push_contact(mk(FricW'(3 * OneQ), 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001));
    push_contact(mk(FricW'(OneQ / 2), 0, 32'h8000_0000, 32'h0, 32'h0));
    push_contact(mk(FricW'(OneQ), 0, 32'h0010_0000, 32'h7FFF_FFFF, 32'h0));     // far outside
    drain_all();

    // Configuration phases, extremes first
    fric_set = '{21'h0, 21'h1, 21'h1F_FFFF, 21'h10_0000, FricW'(OneQ), 21'(OneQ / 3)};
    coh_set  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0002_0000, 32'hFFF0_0000,
                 32'h0};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) begin
        write_reg(REG_CONT_FRICTION, fric_set[ph]);
        write_reg(REG_CONT_COHESION, coh_set[ph]);
      end else begin
        write_reg(REG_CONT_FRICTION, $urandom_range(1, 4 * OneQ));
        write_reg(REG_CONT_COHESION, rand_impulse());
      end
      for (int k = 0; k < 80; k++) begin
        // mid-phase pressure: a long receiver hold-off, then a sender pause
        if (ph == 3 && k == 10) hold_req_cnt++;
        if (ph == 5 && k == 40) begin
          @(negedge clk_i);
          in_ch.valid <= 1'b0;
          while (pending != 0) @(posedge clk_i);
        end
        push_contact(rand_contact());
      end
      drain_all();
    end

    // End of run: pending already zero and latency elapsed
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
src/fcip_pkg.sv
src/fcip_chan_if.sv
src/fcip_isqrt.sv
src/fcip_div.sv
src/fcip_front.sv
src/fcip_queue.sv
src/fcip_back.sv
src/friction_cone_impulse_projector_top.sv
tb/sv/fcip_cone_checker.sv
tb/sv/friction_cone_impulse_projector_top_tb.sv
